### sv/prc_pkg.sv
// shared constants and types of the prime range collector
`default_nettype none

package prc_pkg;

  // width of a number under test and cap on emitted prime results
  localparam int VALUE_BITS = 16;
  localparam int MAX_PRIMES = 63;

  // fixed field widths of the stream payload
  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 13;
  localparam int IN_DATA_BITS = 32;
  localparam int OUT_DATA_BITS = 32;

  // trial divisor never exceeds sqrt(2^VALUE_BITS)
  localparam int D_BITS = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS = 2 * D_BITS;
  localparam int DIV_CNT_BITS = $clog2(VALUE_BITS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NUM   = 7'b0000010,
    S_TEST  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_PRIME = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_SUM   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic d_init;
    logic div_start;
    logic div_step;
    logic d_inc;
    logic n_inc;
    logic count_inc;
    logic push;
    logic push_summary;
  } cmd_t;

  typedef struct packed {
    logic rev_in;
    logic n_lt2;
    logic sq_gt_n;
    logic div_done;
    logic rem_zero;
    logic n_is_hi;
    logic cap_hit;
  } status_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] prime_value;
    logic                  is_summary;
    logic [COUNT_BITS-1:0] prime_count;
    logic                  range_error;
    logic                  cap_overflow;
    logic                  last;
  } result_t;

endpackage

`default_nettype wire

### sv/prc_ctrl.sv
// sequencing state machine for the range walk and trial division
`default_nettype none

module prc_ctrl
  import prc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  input  wire logic    out_free_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.rev_in ? S_SUM : S_NUM;
        end
      end
      S_NUM: begin
        if (status_i.n_lt2) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.d_init = 1'b1;
          state_d      = S_TEST;
        end
      end
      S_TEST: begin
        if (status_i.sq_gt_n) begin
          state_d = S_PRIME;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!status_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (status_i.rem_zero) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.d_inc = 1'b1;
          state_d     = S_TEST;
        end
      end
      S_PRIME: begin
        // past the cap the prime is only counted
        if (status_i.cap_hit) begin
          cmd_o.count_inc = 1'b1;
          state_d         = S_NEXT;
        end else if (out_free_i) begin
          cmd_o.push      = 1'b1;
          cmd_o.count_inc = 1'b1;
          state_d         = S_NEXT;
        end
      end
      S_NEXT: begin
        if (status_i.n_is_hi) begin
          state_d = S_SUM;
        end else begin
          cmd_o.n_inc = 1'b1;
          state_d     = S_NUM;
        end
      end
      S_SUM: begin
        if (out_free_i) begin
          cmd_o.push         = 1'b1;
          cmd_o.push_summary = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/prc_dp.sv
// datapath: range cursor, trial divisor, bit-serial remainder, prime count
`default_nettype none

module prc_dp
  import prc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  input  wire logic [VALUE_BITS-1:0] in_low_i,
  input  wire logic [VALUE_BITS-1:0] in_high_i,
  output status_t                    status_o,
  output result_t                    result_o
);

  logic [VALUE_BITS-1:0]   n_q, n_d, hi_q, hi_d, sh_q, sh_d;
  logic [D_BITS-1:0]       d_q, d_d, rem_q, rem_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [COUNT_BITS-1:0]   count_q, count_d;
  logic                    err_q, err_d;
  logic [SQ_BITS-1:0]      sq;
  logic [D_BITS:0]         rem_sh;

  assign sq     = SQ_BITS'(d_q) * SQ_BITS'(d_q);
  assign rem_sh = {rem_q, sh_q[VALUE_BITS-1]};

  always_comb begin
    n_d     = n_q;
    hi_d    = hi_q;
    sh_d    = sh_q;
    d_d     = d_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    count_d = count_q;
    err_d   = err_q;
    if (cmd_i.load) begin
      n_d     = in_low_i;
      hi_d    = in_high_i;
      count_d = '0;
      err_d   = (in_low_i > in_high_i);
    end
    if (cmd_i.n_inc) begin
      n_d = n_q + 1'b1;
    end
    if (cmd_i.d_init) begin
      d_d = D_BITS'(2);
    end
    if (cmd_i.d_inc) begin
      d_d = d_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      sh_d  = n_q;
      rem_d = '0;
      cnt_d = '0;
    end
    // restoring remainder, one dividend bit per cycle
    if (cmd_i.div_step) begin
      sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= {1'b0, d_q}) begin
        rem_d = D_BITS'(rem_sh - {1'b0, d_q});
      end else begin
        rem_d = D_BITS'(rem_sh);
      end
    end
    if (cmd_i.count_inc) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    hi_q    <= hi_d;
    sh_q    <= sh_d;
    d_q     <= d_d;
    rem_q   <= rem_d;
    count_q <= count_d;
    err_q   <= err_d;
  end

  always_comb begin
    status_o.rev_in   = (in_low_i > in_high_i);
    status_o.n_lt2    = (n_q < VALUE_BITS'(2));
    status_o.sq_gt_n  = (sq > SQ_BITS'(n_q));
    status_o.div_done = (cnt_q == DIV_CNT_BITS'(VALUE_BITS));
    status_o.rem_zero = (rem_q == '0);
    status_o.n_is_hi  = (n_q == hi_q);
    status_o.cap_hit  = (count_q >= COUNT_BITS'(MAX_PRIMES));
  end

  always_comb begin
    result_o = '0;
    if (cmd_i.push_summary) begin
      result_o.is_summary   = 1'b1;
      result_o.prime_count  = count_q;
      result_o.range_error  = err_q;
      result_o.cap_overflow = (count_q > COUNT_BITS'(MAX_PRIMES));
      result_o.last         = 1'b1;
    end else begin
      result_o.prime_value = FIELD_BITS'(n_q);
    end
  end

endmodule

`default_nettype wire

### sv/prc_outreg.sv
// output holding register between the datapath and the result stream
`default_nettype none

module prc_outreg
  import prc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t result_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign result_o = res_q;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= result_i;
    end
  end

endmodule

`default_nettype wire

### sv/prime_range_collector.sv
// top level of the prime range collector: stream ports, controller, datapath
//
// one slave transaction carries an inclusive range [range_low, range_high];
// every number in it is tested by trial division, divisor 2, 3, ... while
// divisor squared is at most the number. each prime found (ascending) goes
// out as one master transaction with tuser = 0, up to 63 of them; then one
// summary transaction follows with tuser = 1, tlast = 1, the total prime
// count, the range error flag (low above high) and the cap overflow flag.
// 0 and 1 are never prime.
// timing: each trial divisor costs a square compare, one bit-serial remainder
// step per dividend bit and a decision; each number adds its S_NUM and S_NEXT
// states, a prime also its last square compare and the push, and the
// remainder unit sets the run time of a range.
// a reversed range goes from idle straight to the summary state, which registers its summary in the output register.
// tready is high only while no range is in work; the next range is taken
// while the summary still waits in the output register.
// a master stall holds the output register and freezes the walk at the
// next result to send. reset drops tvalid and returns the controller to idle.
`default_nettype none

module prime_range_collector
  import prc_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] range_low, [31:16] range_high
  input  wire logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  wire logic                     m_axis_tready_i,
  // [15:0] prime_value, [28:16] prime_count, [29] range_error,
  // [30] cap_overflow, [31] zero
  output logic [OUT_DATA_BITS-1:0]      m_axis_tdata_o,
  // [0] is_summary
  output logic                          m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  cmd_t    cmd;
  status_t status;
  result_t dp_result, out_result;
  logic    out_free;
  logic    in_ready;

  // bits above VALUE_BITS are ignored
  logic [VALUE_BITS-1:0] in_low, in_high;
  assign in_low  = s_axis_tdata_i[VALUE_BITS-1:0];
  assign in_high = s_axis_tdata_i[FIELD_BITS+VALUE_BITS-1:FIELD_BITS];

  assign s_axis_tready_o = in_ready;

  prc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (in_ready),
    .status_i   (status),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  prc_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_low_i  (in_low),
    .in_high_i (in_high),
    .status_o  (status),
    .result_o  (dp_result)
  );

  // holds one result so the walk can continue while the sink stalls
  prc_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd.push),
    .result_i (dp_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  // pack payload, lowest field first
  assign m_axis_tdata_o = {1'b0,
                           out_result.cap_overflow,
                           out_result.range_error,
                           out_result.prime_count,
                           out_result.prime_value};
  assign m_axis_tuser_o = out_result.is_summary;
  assign m_axis_tlast_o = out_result.last;

endmodule

`default_nettype wire
